/* rtl/core/art_pkg.sv */
`timescale 1ns / 1ps

package art_pkg;

   // Table geometry
   localparam int TABLE_SLOTS = 32;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int SLOT_CNT_W  = $clog2(TABLE_SLOTS + 1);

   // Field widths
   localparam int ID_W    = 32;
   localparam int TIME_W  = 32;
   localparam int RETRY_W = 3;
   localparam int DELAY_W = 16;
   localparam int KIND_W  = 3;
   localparam int OP_W    = 2;

   // Configuration registers
   localparam int NUM_DELAYS = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = DELAY_W;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 3'd7;
   localparam logic [DELAY_W-1:0] DELAY_RESET [NUM_DELAYS] =
      '{16'd125, 16'd250, 16'd500, 16'd750, 16'd1000, 16'd2000, 16'd5000};
   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 3'd7;

   // Opcodes
   localparam logic [OP_W-1:0] OP_TRACK = 2'd0;
   localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
   localparam logic [OP_W-1:0] OP_SCAN  = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] K_TRACKED   = 3'd0;
   localparam logic [KIND_W-1:0] K_DUPLICATE = 3'd1;
   localparam logic [KIND_W-1:0] K_FULL      = 3'd2;
   localparam logic [KIND_W-1:0] K_ACKED     = 3'd3;
   localparam logic [KIND_W-1:0] K_UNKNOWN   = 3'd4;
   localparam logic [KIND_W-1:0] K_RESEND    = 3'd5;
   localparam logic [KIND_W-1:0] K_GAVEUP    = 3'd6;
   localparam logic [KIND_W-1:0] K_SCANDONE  = 3'd7;

   // One table entry as held in memory
   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [TIME_W-1:0]  send_time;
      logic [RETRY_W-1:0] retries;
   } entry_type;

endpackage

/* rtl/core/ack_retransmit_tracker.sv */
`timescale 1ns / 1ps

// Retransmission tracker for messages awaiting acknowledgement.
// Items arrive on the req_ channel (valid/ready): opcode 0 tracks a message
// id with its send time, 1 acknowledges an id, 2 is a periodic scan tick
// carrying the current time. Results leave on the rsp_ channel: one result
// for track and ack, and for a tick one result per slot dropped or due for
// resend followed by a scan done result; rsp_last marks the final one.
// Every item walks the whole table through one memory read port, one slot
// per cycle while the rsp_ side does not stall: each slot is read into a
// register and decided on, then the final result is registered in the
// finish state, and the next item is taken only after that, back in idle.
// The table memory has one read and one write port; the read port sets the
// pace of the walk. Opcode 3 is taken and dropped without a result.
// A stalled receiver holds the result register; the walk pauses on the
// slot that has a result to give and resumes when the register frees. A new
// item is taken once the previous final result sits in the output register.
// Reset clears all slot valid bits and loads the default delays and retry
// limit; the user must make csr_ writes that change them only while the
// block is idle, as the block itself does not enforce this.
module ack_retransmit_tracker (
   input  logic                            clock,
   input  logic                            reset,
   // Input items
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [art_pkg::OP_W-1:0]        req_opcode,
   input  logic [art_pkg::ID_W-1:0]        req_message_id,
   input  logic [art_pkg::TIME_W-1:0]      req_send_time,
   input  logic [art_pkg::TIME_W-1:0]      req_now_time,
   // Result items
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [art_pkg::KIND_W-1:0]      rsp_kind,
   output logic [art_pkg::ID_W-1:0]        rsp_result_id,
   output logic [art_pkg::RETRY_W-1:0]     rsp_retry_count,
   output logic                            rsp_last,
   // Configuration writes
   input  logic                            csr_wr_en,
   input  logic [art_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [art_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   import art_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // Control state
   logic [1:0]            state_ff, state_in;
   logic [SLOT_CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic                  eval_valid_ff, eval_valid_in;
   logic [SLOT_W-1:0]     eval_idx_ff, eval_idx_in;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     found_idx_ff, found_idx_in;
   logic                  free_ff, free_in;
   logic [SLOT_W-1:0]     free_idx_ff, free_idx_in;
   logic [TABLE_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   // Item held during the walk
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] send_ff;
   logic [TIME_W-1:0] now_ff;

   // Configuration
   logic [DELAY_W-1:0] delay_ff [NUM_DELAYS];
   logic [RETRY_W-1:0] limit_ff;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic [RETRY_W-1:0]  rcount_ff, rcount_in;
   logic                last_ff, last_in;
   logic                out_load;
   logic                out_free;

   // Table memory
   entry_type         mem [TABLE_SLOTS];
   entry_type         rd_entry_ff;
   logic              rd_en;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type         wr_entry;

   // Slot evaluation
   logic               eval_slot_valid;
   logic               id_match;
   logic               give_up;
   logic               due;
   logic               eval_emit;
   logic               advance;
   logic [RETRY_W-1:0] dsel;
   logic [TIME_W:0]    deadline;
   logic [RETRY_W-1:0] retry_next;
   logic               walk_done;

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_result_id   = rid_ff;
   assign rsp_retry_count = rcount_ff;
   assign rsp_last        = last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Per-slot decisions on the entry just read
   assign eval_slot_valid = slot_valid_ff[eval_idx_ff];
   assign id_match        = eval_slot_valid && (rd_entry_ff.id == id_ff);
   assign give_up         = rd_entry_ff.retries >= limit_ff;
   assign dsel            = (rd_entry_ff.retries >= RETRY_W'(NUM_DELAYS - 1))
                            ? RETRY_W'(NUM_DELAYS - 1) : rd_entry_ff.retries;
   assign deadline        = {1'b0, rd_entry_ff.send_time}
                            + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay_ff[dsel]};
   assign due             = deadline < {1'b0, now_ff};
   assign retry_next      = rd_entry_ff.retries + RETRY_W'(1);
   assign eval_emit       = eval_valid_ff && (op_ff == OP_SCAN) && eval_slot_valid
                            && (give_up || due);
   assign advance         = !eval_emit || out_free;
   assign rd_en           = (state_ff == ST_WALK) && advance
                            && (rd_idx_ff < SLOT_CNT_W'(TABLE_SLOTS));
   assign walk_done       = (rd_idx_ff == SLOT_CNT_W'(TABLE_SLOTS)) && !eval_valid_ff;

   // Sequencer, table updates and result selection
   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      slot_valid_in = slot_valid_ff;
      out_load      = 1'b0;
      kind_in       = kind_ff;
      rid_in        = rid_ff;
      rcount_in     = rcount_ff;
      last_in       = last_ff;
      wr_en         = 1'b0;
      wr_addr       = eval_idx_ff;
      wr_entry      = rd_entry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rd_idx_in     = '0;
               eval_valid_in = 1'b0;
               found_in      = 1'b0;
               free_in       = 1'b0;
               if (req_opcode == OP_TRACK || req_opcode == OP_ACK
                   || req_opcode == OP_SCAN) begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // Decide on the slot held in the read register
            if (eval_valid_ff && advance) begin
               if (op_ff == OP_SCAN) begin
                  if (eval_emit) begin
                     out_load = 1'b1;
                     rid_in   = rd_entry_ff.id;
                     last_in  = 1'b0;
                     if (give_up) begin
                        slot_valid_in[eval_idx_ff] = 1'b0;
                        kind_in   = K_GAVEUP;
                        rcount_in = rd_entry_ff.retries;
                     end else begin
                        wr_en            = 1'b1;
                        wr_entry.retries = retry_next;
                        kind_in          = K_RESEND;
                        rcount_in        = retry_next;
                     end
                  end
               end else begin
                  if (id_match && !found_ff) begin
                     found_in     = 1'b1;
                     found_idx_in = eval_idx_ff;
                  end
                  if (!eval_slot_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = eval_idx_ff;
                  end
               end
            end
            // Issue the next read
            if (advance) begin
               eval_valid_in = rd_en;
               eval_idx_in   = rd_idx_ff[SLOT_W-1:0];
               if (rd_en) begin
                  rd_idx_in = rd_idx_ff + SLOT_CNT_W'(1);
               end
            end
            if (walk_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load  = 1'b1;
               rid_in    = id_ff;
               rcount_in = '0;
               last_in   = 1'b1;
               state_in  = ST_IDLE;
               priority if (op_ff == OP_SCAN) begin
                  kind_in = K_SCANDONE;
                  rid_in  = '0;
               end else if (op_ff == OP_ACK) begin
                  if (found_ff) begin
                     slot_valid_in[found_idx_ff] = 1'b0;
                     kind_in = K_ACKED;
                  end else begin
                     kind_in = K_UNKNOWN;
                  end
               end else begin
                  priority if (found_ff) begin
                     kind_in = K_DUPLICATE;
                  end else if (!free_ff) begin
                     kind_in = K_FULL;
                  end else begin
                     slot_valid_in[free_idx_ff] = 1'b1;
                     wr_en              = 1'b1;
                     wr_addr            = free_idx_ff;
                     wr_entry.id        = id_ff;
                     wr_entry.send_time = send_ff;
                     wr_entry.retries   = '0;
                     kind_in            = K_TRACKED;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Output valid
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         eval_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         free_ff       <= 1'b0;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         eval_valid_ff <= eval_valid_in;
         found_ff      <= found_in;
         free_ff       <= free_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      eval_idx_ff  <= eval_idx_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
      kind_ff      <= kind_in;
      rid_ff       <= rid_in;
      rcount_ff    <= rcount_in;
      last_ff      <= last_in;
      if (req_valid && req_ready) begin
         op_ff   <= req_opcode;
         id_ff   <= req_message_id;
         send_ff <= req_send_time;
         now_ff  <= req_now_time;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DELAYS; i++) begin
            delay_ff[i] <= DELAY_RESET[i];
         end
         limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_RETRY_LIMIT) begin
            limit_ff <= csr_wr_data[RETRY_W-1:0];
         end else begin
            delay_ff[csr_index] <= csr_wr_data;
         end
      end
   end

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_idx_ff[SLOT_W-1:0]];
      end
   end

endmodule
